@@ rtl/core/msfd_pkg.sv @@
package msfd_pkg;

	// header layout, byte offsets from the first magic byte
	localparam int unsigned VER_OFF     = 4;
	localparam int unsigned LEN_OFF     = 32;
	localparam int unsigned FETCH_BYTES = 4;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC   = 2'd0,
		CFG_VERSION = 2'd1,
		CFG_MAX     = 2'd2
	} cfg_idx_t;

	// where the header read pointer restarts
	typedef enum logic [1:0] {
		RD_KEEP = 2'd0,
		RD_ZERO = 2'd1,
		RD_VER  = 2'd2,
		RD_LEN  = 2'd3
	} rd_set_t;

	// what the output register loads
	typedef enum logic [1:0] {
		OUT_NONE = 2'd0,
		OUT_HDR  = 2'd1,
		OUT_PAY  = 2'd2,
		OUT_ERR  = 2'd3
	} out_sel_t;

	typedef struct packed {
		logic     append;
		logic     issue;
		logic     hold;
		rd_set_t  rd_set;
		logic     drop_found;
		logic     drop_keep3;
		logic     drop_one;
		logic     clr_fill;
		logic     cap_len;
		logic     ld_remain;
		out_sel_t out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_needed;
		logic rd_vld;
		logic rd_lt_fill;
		logic rd_lt_ver_end;
		logic rd_lt_len_end;
		logic rd_lt_hdr;
		logic match;
		logic scan_last;
		logic found_full;
		logic ver_last;
		logic hdr_ok;
		logic len_last;
		logic hdr_last;
		logic too_big;
		logic plen_zero;
		logic remain_last;
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/core/msfd_in_if.sv @@
interface msfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

@@ rtl/core/msfd_out_if.sv @@
interface msfd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_start;
	logic       frame_end;
	logic       error_flag;

	modport source (output valid, output out_byte, output frame_start, output frame_end,
		output error_flag, input ready);
	modport sink (input valid, input out_byte, input frame_start, input frame_end,
		input error_flag, output ready);
endinterface

@@ rtl/core/msfd_ctrl.sv @@
module msfd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  msfd_pkg::dp_sts_t sts,
	output msfd_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SCAN,
		ST_VER,
		ST_LEN,
		ST_SIZE,
		ST_EMIT,
		ST_PAYLOAD,
		ST_ERROR
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd         = '0;
		cmd.rd_set  = msfd_pkg::RD_KEEP;
		cmd.out_sel = msfd_pkg::OUT_NONE;
		in_ready    = 1'b0;
		state_d     = state_q;
		case (state_q)
			ST_HUNT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.append = 1'b1;
					cmd.rd_set = msfd_pkg::RD_ZERO;
					if (sts.scan_needed) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (sts.match) begin
					cmd.drop_found = 1'b1;
					if (sts.found_full) begin
						cmd.rd_set = msfd_pkg::RD_VER;
						state_d    = ST_VER;
					end else begin
						state_d = ST_HUNT;
					end
				end else if (sts.scan_last) begin
					cmd.drop_keep3 = 1'b1;
					state_d        = ST_HUNT;
				end else begin
					cmd.issue = sts.rd_lt_fill;
				end
			end
			ST_VER: begin
				if (sts.ver_last) begin
					if (sts.hdr_ok) begin
						cmd.rd_set = msfd_pkg::RD_LEN;
						state_d    = ST_LEN;
					end else begin
						// slip one byte and hunt again over what is buffered
						cmd.drop_one = 1'b1;
						cmd.rd_set   = msfd_pkg::RD_ZERO;
						state_d      = ST_SCAN;
					end
				end else begin
					cmd.issue = sts.rd_lt_ver_end;
				end
			end
			ST_LEN: begin
				if (sts.len_last) begin
					cmd.cap_len = 1'b1;
					state_d     = ST_SIZE;
				end else begin
					cmd.issue = sts.rd_lt_len_end;
				end
			end
			ST_SIZE: begin
				if (sts.too_big) begin
					if (sts.out_free) begin
						cmd.out_sel = msfd_pkg::OUT_ERR;
						state_d     = ST_ERROR;
					end
				end else begin
					cmd.rd_set    = msfd_pkg::RD_ZERO;
					cmd.ld_remain = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.issue = sts.rd_lt_hdr && (!sts.rd_vld || sts.out_free);
				cmd.hold  = sts.rd_vld && !sts.out_free;
				if (sts.rd_vld && sts.out_free) begin
					cmd.out_sel = msfd_pkg::OUT_HDR;
					if (sts.hdr_last) begin
						cmd.clr_fill = 1'b1;
						state_d      = sts.plen_zero ? ST_HUNT : ST_PAYLOAD;
					end
				end
			end
			ST_PAYLOAD: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					cmd.out_sel = msfd_pkg::OUT_PAY;
					if (sts.remain_last) begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_ERROR: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					cmd.out_sel = msfd_pkg::OUT_ERR;
				end
			end
			default: begin
				state_d = ST_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/msfd_dp.sv @@
module msfd_dp #(
	parameter int unsigned HEADER_BYTES = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [msfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [msfd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [7:0]                          in_byte,
	input  msfd_pkg::dp_cmd_t                   cmd,
	output msfd_pkg::dp_sts_t                   sts,
	output logic                                out_valid,
	output logic [7:0]                          out_byte,
	output logic                                out_start,
	output logic                                out_end,
	output logic                                out_err,
	input  logic                                out_ready
);

	localparam int unsigned AW = $clog2(HEADER_BYTES);
	localparam int unsigned FW = $clog2(HEADER_BYTES + 1);
	localparam int unsigned SW = FW + 1;
	localparam logic [FW-1:0] HB_F = FW'(HEADER_BYTES);

	// header buffer is circular: head marks the oldest byte
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [FW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(HEADER_BYTES)) begin
			sum = sum - SW'(HEADER_BYTES);
		end
		return sum[AW-1:0];
	endfunction

	logic [7:0]    hdr_mem_q [HEADER_BYTES];
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] rd_off_q;
	logic [FW-1:0] rd_pos_s1;
	logic          rd_vld_s1;
	logic [7:0]    rd_data_s1;
	logic [31:0]   win_q;
	logic [31:0]   plen_q;
	logic [31:0]   remain_q;
	logic [31:0]   magic_q;
	logic [15:0]   version_q;
	logic [31:0]   max_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_start_q;
	logic          out_end_q;
	logic          out_err_q;

	logic [FW-1:0] fill_base;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [31:0]   cand;
	logic [FW-1:0] found;
	logic [32:0]   size_sum;
	logic          out_free;

	assign fill_base = (fill_q >= HB_F) ? '0 : fill_q;
	assign wr_addr   = wrap_add(head_q, fill_base);
	assign rd_addr   = wrap_add(head_q, rd_off_q);
	assign cand      = {win_q[23:0], rd_data_s1};
	assign found     = rd_pos_s1 - FW'(3);
	assign size_sum  = {1'b0, plen_q} + 33'(HEADER_BYTES);
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		sts.scan_needed   = (fill_q >= FW'(3)) && (fill_q < HB_F);
		sts.rd_vld        = rd_vld_s1;
		sts.rd_lt_fill    = rd_off_q < fill_q;
		sts.rd_lt_ver_end = rd_off_q < FW'(msfd_pkg::VER_OFF + msfd_pkg::FETCH_BYTES);
		sts.rd_lt_len_end = rd_off_q < FW'(msfd_pkg::LEN_OFF + msfd_pkg::FETCH_BYTES);
		sts.rd_lt_hdr     = rd_off_q < HB_F;
		sts.match         = rd_vld_s1 && (rd_pos_s1 >= FW'(3)) && (cand == magic_q);
		sts.scan_last     = rd_vld_s1 && (rd_pos_s1 == fill_q - FW'(1));
		sts.found_full    = (rd_pos_s1 == FW'(3)) && (fill_q == HB_F);
		sts.ver_last      = rd_vld_s1 &&
			(rd_pos_s1 == FW'(msfd_pkg::VER_OFF + msfd_pkg::FETCH_BYTES - 1));
		// version and header length sit back to back in the fetched word
		sts.hdr_ok        = (cand[31:16] == version_q) && (cand[15:0] == 16'(HEADER_BYTES));
		sts.len_last      = rd_vld_s1 &&
			(rd_pos_s1 == FW'(msfd_pkg::LEN_OFF + msfd_pkg::FETCH_BYTES - 1));
		sts.hdr_last      = rd_vld_s1 && (rd_pos_s1 == HB_F - FW'(1));
		sts.too_big       = size_sum > {1'b0, max_q};
		sts.plen_zero     = plen_q == 32'd0;
		sts.remain_last   = remain_q == 32'd1;
		sts.out_free      = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			hdr_mem_q[wr_addr] <= in_byte;
		end
		if (cmd.issue) begin
			rd_data_s1 <= hdr_mem_q[rd_addr];
			rd_pos_s1  <= rd_off_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !cmd.hold) begin
			win_q <= cand;
		end
		if (cmd.cap_len) begin
			plen_q <= cand;
		end
		case (cmd.out_sel)
			msfd_pkg::OUT_HDR: begin
				out_byte_q  <= rd_data_s1;
				out_start_q <= rd_pos_s1 == '0;
				out_end_q   <= (rd_pos_s1 == HB_F - FW'(1)) && (plen_q == 32'd0);
				out_err_q   <= 1'b0;
			end
			msfd_pkg::OUT_PAY: begin
				out_byte_q  <= in_byte;
				out_start_q <= 1'b0;
				out_end_q   <= remain_q == 32'd1;
				out_err_q   <= 1'b0;
			end
			msfd_pkg::OUT_ERR: begin
				out_byte_q  <= 8'd0;
				out_start_q <= 1'b0;
				out_end_q   <= 1'b0;
				out_err_q   <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fill_q      <= '0;
			rd_off_q    <= '0;
			rd_vld_s1   <= 1'b0;
			remain_q    <= '0;
			magic_q     <= 32'd0;
			version_q   <= 16'd1;
			max_q       <= 32'd65536;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				fill_q <= fill_base + FW'(1);
			end else if (cmd.drop_found) begin
				head_q <= wrap_add(head_q, found);
				fill_q <= fill_q - found;
			end else if (cmd.drop_keep3) begin
				head_q <= wrap_add(head_q, fill_q - FW'(3));
				fill_q <= FW'(3);
			end else if (cmd.drop_one) begin
				head_q <= wrap_add(head_q, FW'(1));
				fill_q <= fill_q - FW'(1);
			end else if (cmd.clr_fill) begin
				fill_q <= '0;
			end

			case (cmd.rd_set)
				msfd_pkg::RD_ZERO: rd_off_q <= '0;
				msfd_pkg::RD_VER:  rd_off_q <= FW'(msfd_pkg::VER_OFF);
				msfd_pkg::RD_LEN:  rd_off_q <= FW'(msfd_pkg::LEN_OFF);
				default: begin
					if (cmd.issue) begin
						rd_off_q <= rd_off_q + FW'(1);
					end
				end
			endcase

			rd_vld_s1 <= cmd.issue || (rd_vld_s1 && cmd.hold);

			if (cmd.ld_remain) begin
				remain_q <= plen_q;
			end else if (cmd.out_sel == msfd_pkg::OUT_PAY) begin
				remain_q <= remain_q - 32'd1;
			end

			if (cfg_we) begin
				case (cfg_index)
					msfd_pkg::CFG_MAGIC:   magic_q   <= cfg_data;
					msfd_pkg::CFG_VERSION: version_q <= cfg_data[15:0];
					msfd_pkg::CFG_MAX:     max_q     <= cfg_data;
					default: begin
					end
				endcase
			end

			if (cmd.out_sel != msfd_pkg::OUT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_start = out_start_q;
	assign out_end   = out_end_q;
	assign out_err   = out_err_q;

endmodule

@@ rtl/core/magic_sync_frame_deframer_core.sv @@
// magic word sync deframer: takes one stream byte per word on stream_in, hunts for the
// four byte magic word, checks the header version and header length, reads the 32 bit
// big-endian payload length at offset 32 and, when header plus payload fits in the
// configured frame size limit, sends the whole header and then the payload on frame_out
// with frame_start on the first and frame_end on the last byte of the frame. an oversize
// frame raises error_flag and the block then answers every later byte with an error word
// until reset. rate: payload and error bytes go through at one byte per cycle while the
// receiver keeps ready high; a byte taken while hunting is stored, then the buffered bytes
// are scanned through the single read port of the header buffer, all of them when no magic
// is found, else up to the magic word, which normally sits at the start of the buffer; no
// new byte is taken during the scan; a complete header then has its version and header
// length read, its payload length read and its size compared with the limit, then the
// header leaves at one byte per cycle while the receiver keeps ready high; a header that
// fails its checks instead drops one byte and rescans the remaining buffered bytes
module magic_sync_frame_deframer_core #(
	parameter int unsigned HEADER_BYTES = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	msfd_in_if.sink                         stream_in,
	msfd_out_if.source                      frame_out,
	input  logic                            cfg_we,
	input  logic [msfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msfd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// command and status between sequencer and buffer datapath
	msfd_pkg::dp_cmd_t cmd;
	msfd_pkg::dp_sts_t sts;

	// sequencer: hunt, scan, header checks, burst, payload, sticky error
	msfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream_in.valid),
		.in_ready (stream_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// header buffer, magic matcher, length math and output word register
	msfd_dp #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (stream_in.data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (frame_out.valid),
		.out_byte  (frame_out.out_byte),
		.out_start (frame_out.frame_start),
		.out_end   (frame_out.frame_end),
		.out_err   (frame_out.error_flag),
		.out_ready (frame_out.ready)
	);

endmodule

@@ bench/msfd_frame_checker.sv @@
module msfd_frame_checker #(
	parameter int unsigned HEADER_BYTES = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	msfd_in_if                              stream_in,
	msfd_out_if                             frame_out,
	input  logic                            cfg_we,
	input  logic [msfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                     fail_count,
	output int unsigned                     pending,
	output int unsigned                     words_seen,
	output int unsigned                     frames_seen,
	output int unsigned                     error_words
);

	localparam int unsigned VER_OFF  = msfd_pkg::VER_OFF;
	localparam int unsigned LEN_OFF  = msfd_pkg::LEN_OFF;
	localparam int unsigned HLEN_OFF = VER_OFF + 2;

	typedef enum logic [1:0] {
		MODE_HUNT    = 2'd0,
		MODE_PAYLOAD = 2'd1,
		MODE_STUCK   = 2'd2
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       err;
	} frame_word_t;

	logic [31:0] magic_word_r;
	logic [15:0] version_r;
	logic [31:0] max_bytes_r;

	logic [7:0]  hdr_buf [HEADER_BYTES];
	int unsigned hdr_fill;
	logic [31:0] pay_left;
	parse_mode_t mode;

	frame_word_t expected_words [$];

	function automatic bit magic_at(int unsigned i);
		return {hdr_buf[i], hdr_buf[i+1], hdr_buf[i+2], hdr_buf[i+3]} == magic_word_r;
	endfunction

	function automatic void drop_front(int unsigned n);
		int unsigned k;
		if (n >= hdr_fill) begin
			hdr_fill = 0;
		end else begin
			for (k = 0; k < hdr_fill - n; k++)
				hdr_buf[k] = hdr_buf[k + n];
			hdr_fill -= n;
		end
	endfunction

	function automatic void push_word(logic [7:0] d, logic f, logic l, logic e);
		frame_word_t w;
		w = {d, f, l, e};
		expected_words.insert(expected_words.size(), w);
	endfunction

	// one stream byte in, zero or more expected frame words out
	function automatic void deframe_byte(logic [7:0] b);
		int unsigned i;
		int unsigned found;
		logic [31:0] plen;
		logic [32:0] total;
		bit          done;
		if (mode == MODE_PAYLOAD) begin
			if (pay_left != 0)
				pay_left--;
			push_word(b, 1'b0, pay_left == 0, 1'b0);
			if (pay_left == 0) begin
				mode = MODE_HUNT;
				hdr_fill = 0;
			end
			return;
		end
		if (mode != MODE_HUNT) begin
			push_word(8'h00, 1'b0, 1'b0, 1'b1);
			return;
		end

		if (hdr_fill >= HEADER_BYTES)
			hdr_fill = 0;
		hdr_buf[hdr_fill] = b;
		hdr_fill++;

		done = 1'b0;
		while (!done) begin
			if (hdr_fill < 4) begin
				done = 1'b1;
			end else begin
				found = hdr_fill;
				for (i = 0; i + 4 <= hdr_fill; i++)
					if (found == hdr_fill && magic_at(i))
						found = i;
				if (found == hdr_fill) begin
					// no sync anywhere, keep a possible partial magic
					drop_front(hdr_fill - 3);
					done = 1'b1;
				end else begin
					if (found > 0)
						drop_front(found);
					if (hdr_fill < HEADER_BYTES) begin
						done = 1'b1;
					end else if ({hdr_buf[VER_OFF], hdr_buf[VER_OFF+1]} != version_r ||
						{hdr_buf[HLEN_OFF], hdr_buf[HLEN_OFF+1]} != 16'(HEADER_BYTES)) begin
						drop_front(1);
					end else begin
						plen = {hdr_buf[LEN_OFF], hdr_buf[LEN_OFF+1], hdr_buf[LEN_OFF+2],
							hdr_buf[LEN_OFF+3]};
						total = 33'(HEADER_BYTES) + {1'b0, plen};
						if (total > {1'b0, max_bytes_r}) begin
							mode = MODE_STUCK;
							push_word(8'h00, 1'b0, 1'b0, 1'b1);
						end else begin
							for (i = 0; i < HEADER_BYTES; i++)
								push_word(hdr_buf[i], i == 0,
									plen == 0 && i == HEADER_BYTES - 1, 1'b0);
							hdr_fill = 0;
							if (plen != 0) begin
								pay_left = plen;
								mode = MODE_PAYLOAD;
							end
						end
						done = 1'b1;
					end
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		frame_word_t got;
		frame_word_t want;
		if (!arst_n) begin
			magic_word_r = 32'h0;
			version_r = 16'h0001;
			max_bytes_r = 32'd65536;
			hdr_fill = 0;
			pay_left = 32'h0;
			mode = MODE_HUNT;
			expected_words.delete();
			fail_count = 0;
			words_seen = 0;
			frames_seen = 0;
			error_words = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					msfd_pkg::CFG_MAGIC:   magic_word_r = cfg_data;
					msfd_pkg::CFG_VERSION: version_r = cfg_data[15:0];
					msfd_pkg::CFG_MAX:     max_bytes_r = cfg_data;
					default:               ;
				endcase
			end
			if (stream_in.valid && stream_in.ready)
				deframe_byte(stream_in.data_byte);
			if (frame_out.valid && frame_out.ready) begin
				got = {frame_out.out_byte, frame_out.frame_start, frame_out.frame_end,
					frame_out.error_flag};
				words_seen++;
				if (got.err)
					error_words++;
				else if (got.last)
					frames_seen++;
				if (expected_words.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected word out_byte %h start %b end %b error %b",
						$time, got.data, got.first, got.last, got.err);
				end else begin
					want = expected_words[0];
					expected_words.delete(0);
					if (got.data !== want.data) begin
						fail_count++;
						$display("%0t: out_byte expected %h got %h", $time, want.data, got.data);
					end
					if (got.first !== want.first) begin
						fail_count++;
						$display("%0t: frame_start expected %b got %b", $time, want.first,
							got.first);
					end
					if (got.last !== want.last) begin
						fail_count++;
						$display("%0t: frame_end expected %b got %b", $time, want.last,
							got.last);
					end
					if (got.err !== want.err) begin
						fail_count++;
						$display("%0t: error_flag expected %b got %b", $time, want.err,
							got.err);
					end
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule

@@ bench/tb_magic_sync_frame_deframer_core.sv @@
module tb_magic_sync_frame_deframer_core;

	localparam int unsigned HDR_BYTES     = 40;
	localparam int unsigned MAGIC_BYTES   = 4;
	localparam int unsigned MAX_GAP       = 10;
	// settle time after a drain, to let a full-buffer rescan finish
	localparam int unsigned SETTLE_CYCLES = 3 * HDR_BYTES;
	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned RANDOM_BYTES  = 70;
	localparam int unsigned SEGMENTS      = 1;
	localparam int unsigned VER_OFF       = msfd_pkg::VER_OFF;
	localparam int unsigned LEN_OFF       = msfd_pkg::LEN_OFF;
	// index past the last register, writes there must be ignored
	localparam logic [msfd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [msfd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [msfd_pkg::CFG_DATA_W-1:0] cfg_data;

	msfd_in_if  stream_in ();
	msfd_out_if frame_out ();

	int unsigned fail_count;
	int unsigned pending;
	int unsigned words_seen;
	int unsigned frames_seen;
	int unsigned error_words;

	int unsigned bytes_sent;
	int unsigned frames_good;
	int unsigned frames_bad;
	int unsigned quiet_cycles;
	int unsigned rx_wait;
	int unsigned rx_hold;

	// magic currently programmed, header filler bytes avoid its lead byte
	logic [31:0] cur_magic;
	// when set both sides run without idling
	bit          calm;

	magic_sync_frame_deframer_core #(
		.HEADER_BYTES(HDR_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream_in(stream_in),
		.frame_out(frame_out),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	msfd_frame_checker #(
		.HEADER_BYTES(HDR_BYTES)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream_in  (stream_in),
		.frame_out  (frame_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.words_seen (words_seen),
		.frames_seen(frames_seen),
		.error_words(error_words)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: ends the run when no word moves on either channel for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((stream_in.valid && stream_in.ready) ||
			(frame_out.valid && frame_out.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d words outstanding", $time,
				QUIET_LIMIT, pending);
			$display("** magic_sync_frame_deframer_core: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver: after each accepted word hold ready low for a random number of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_out.ready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (frame_out.valid && frame_out.ready)
				rx_hold = calm ? 0 : $urandom_range(0, MAX_GAP);
			else if (rx_wait != 0)
				rx_hold = rx_wait - 1;
			else
				rx_hold = 0;
			rx_wait <= rx_hold;
			frame_out.ready <= (rx_hold == 0);
		end
	end

	function automatic int unsigned draw_gap();
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// any byte except the lead byte of the magic, so no false sync inside a header
	function automatic logic [7:0] filler();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == cur_magic[31:24]);
		return b;
	endfunction

	// lead byte in the upper half and unique within the word, so it never shows up
	// in version, length or small payload length fields
	function automatic logic [31:0] random_magic();
		logic [7:0]  lead;
		logic [7:0]  b;
		logic [31:0] w;
		int unsigned k;
		lead = 8'($urandom_range(8'h80, 8'hFE));
		w = {lead, 24'h0};
		for (k = 1; k < MAGIC_BYTES; k++) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == lead);
			w[8*(3-k) +: 8] = b;
		end
		return w;
	endfunction

	function automatic logic [15:0] random_version();
		return {1'b0, 7'($urandom()), 1'b0, 7'($urandom())};
	endfunction

	// one stream word, with a random gap in front; valid stays high when no gap follows
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			stream_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_in.valid <= 1'b1;
		stream_in.data_byte <= b;
		@(posedge clk);
		while (!stream_in.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// stop sending and wait for every expected word, optionally for the block to go quiet
	task automatic drain(input bit settle);
		stream_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// upper bits of the version write are junk on purpose
	task automatic program_regs(input logic [31:0] magic, input logic [15:0] ver,
		input logic [31:0] max_bytes, input bit poke_spare);
		if (poke_spare) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_SPARE;
			cfg_data <= $urandom();
			@(posedge clk);
		end
		cfg_we <= 1'b1;
		cfg_index <= msfd_pkg::CFG_MAGIC;
		cfg_data <= magic;
		@(posedge clk);
		cfg_index <= msfd_pkg::CFG_VERSION;
		cfg_data <= {16'($urandom()), ver};
		@(posedge clk);
		cfg_index <= msfd_pkg::CFG_MAX;
		cfg_data <= max_bytes;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_magic = magic;
	endtask

	// magic, version, header length, filler, payload length at its offset, filler
	task automatic send_header(input logic [15:0] ver, input logic [15:0] hlen,
		input logic [31:0] plen);
		int unsigned i;
		logic [7:0]  b;
		for (i = 0; i < HDR_BYTES; i++) begin
			if (i < MAGIC_BYTES)
				b = cur_magic[8*(3-i) +: 8];
			else if (i == VER_OFF)
				b = ver[15:8];
			else if (i == VER_OFF + 1)
				b = ver[7:0];
			else if (i == VER_OFF + 2)
				b = hlen[15:8];
			else if (i == VER_OFF + 3)
				b = hlen[7:0];
			else if (i >= LEN_OFF && i < LEN_OFF + 4)
				b = plen[8*(3-(i-LEN_OFF)) +: 8];
			else
				b = filler();
			send_byte(b);
		end
	endtask

	task automatic send_payload(input int unsigned n);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	// junk between frames, sometimes with the first bytes of a magic before or after it
	task automatic send_noise();
		int unsigned part;
		int unsigned k;
		bit          tail;
		part = $urandom_range(0, MAGIC_BYTES - 1);
		tail = 1'($urandom_range(0, 1));
		if (!tail)
			for (k = 0; k < part; k++)
				send_byte(cur_magic[8*(3-k) +: 8]);
		repeat ($urandom_range(1, 6)) send_byte(filler());
		if (tail)
			for (k = 0; k < part; k++)
				send_byte(cur_magic[8*(3-k) +: 8]);
	endtask

	initial begin : stimulus
		int unsigned seg;
		int unsigned seg_end;
		int unsigned pick;
		int unsigned plen;
		logic [15:0] ver;

		arst_n <= 1'b0;
		stream_in.valid <= 1'b0;
		stream_in.data_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= msfd_pkg::CFG_MAGIC;
		cfg_data <= '0;
		calm = 1'b0;
		cur_magic = 32'h0;
		bytes_sent = 0;
		frames_good = 0;
		frames_bad = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: all-zero magic, version 1; junk first, it only fills the buffer
		send_byte(8'h5A);
		send_byte(8'hA5);
		send_byte(8'h3C);
		// zero payload: frame_end lands on the last header byte
		send_header(16'h0001, 16'(HDR_BYTES), 32'd0);
		frames_good++;

		// all-ones magic, lowest version, limit one above the header: one payload byte fits
		drain(1'b1);
		program_regs(32'hFFFF_FFFF, 16'h0000, HDR_BYTES + 1, 1'b1);
		send_header(16'h0000, 16'(HDR_BYTES), 32'd1);
		send_byte(8'h80);
		frames_good++;

		// random part: mostly well-formed frames, some broken headers and junk
		for (seg = 0; seg < SEGMENTS; seg++) begin
			drain(1'b1);
			ver = random_version();
			program_regs(random_magic(), ver, $urandom_range(HDR_BYTES + 40, 32'hFFFF_FFFE),
				1'b0);
			seg_end = bytes_sent + RANDOM_BYTES / SEGMENTS;
			while (bytes_sent < seg_end) begin
				calm = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					case ($urandom_range(0, 5))
						0:       plen = 0;
						1:       plen = $urandom_range(17, 40);
						default: plen = $urandom_range(1, 16);
					endcase
					send_header(ver, 16'(HDR_BYTES), plen);
					send_payload(plen);
					frames_good++;
				end else if (pick < 72) begin
					send_header(ver ^ 16'h0001, 16'(HDR_BYTES), $urandom_range(0, 40));
					frames_bad++;
				end else if (pick < 80) begin
					send_header(ver, 16'(HDR_BYTES) ^ (16'd1 << $urandom_range(0, 6)),
						$urandom_range(0, 40));
					frames_bad++;
				end else if (pick < 95) begin
					send_noise();
				end else begin
					// sender holds off until the output side has caught up
					drain(1'b0);
				end
			end
		end
		calm = 1'b0;

		// oversize frame last: the sum only exceeds the limit when computed without wrap,
		// after it every byte comes back as an error word
		drain(1'b1);
		ver = random_version();
		program_regs(random_magic(), ver, 32'hFFFF_FFFF, 1'b0);
		send_header(ver, 16'(HDR_BYTES), 32'hFFFF_FFFF);
		frames_bad++;
		send_payload(8);

		drain(1'b1);
		$display("sent %0d stream bytes: %0d valid frames, %0d broken or oversize headers",
			bytes_sent, frames_good, frames_bad);
		$display("checked %0d output words: %0d complete frames, %0d error words",
			words_seen, frames_seen, error_words);
		if (fail_count == 0 && pending == 0)
			$display("** magic_sync_frame_deframer_core: PASSED **");
		else
			$display("** magic_sync_frame_deframer_core: FAILED **");
		$finish;
	end

endmodule
